// ===== hdl/midpoint_ellipse_rasterizer_macros.svh =====
// assertion shorthands shared by the rasterizer modules
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH

// same-cycle implication, off during reset
`define MER_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mer assertion failed");

// next-cycle implication, off during reset
`define MER_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mer assertion failed");

`endif

// ===== hdl/mer_pkg.sv =====
package mer_pkg;

   // fixed field widths
   localparam int PIX_W     = 14;
   localparam int HALF_W    = 12;
   localparam int CENTER_W  = 12;
   localparam int RAD_W     = 11;
   localparam int SQ_W      = 22;
   localparam int COLOR_W   = 24;
   localparam int DEC_W     = 48;
   localparam int MUL_W     = 32;
   localparam int PC_W      = 5;
   localparam int CSR_IDX_W = 2;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HALF_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HALF_Y = 2'd1;
   localparam logic [HALF_W-1:0]    HALF_X_RESET      = 12'd320;
   localparam logic [HALF_W-1:0]    HALF_Y_RESET      = 12'd240;

   // command codes
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // program entry points
   localparam logic [PC_W-1:0] PC_START      = 5'd0;
   localparam logic [PC_W-1:0] PC_ADVANCE    = 5'd5;
   localparam logic [PC_W-1:0] PC_SWITCH     = 5'd13;
   localparam logic [PC_W-1:0] PC_REGION_TWO = 5'd20;

   // accumulator shift amounts: times 1, 4, 8
   localparam logic [1:0] SH_1 = 2'd0;
   localparam logic [1:0] SH_4 = 2'd2;
   localparam logic [1:0] SH_8 = 2'd3;

   typedef enum logic [3:0] {
      OP_RX, OP_RY, OP_RX2, OP_RY2, OP_X, OP_Y, OP_XS, OP_YM, OP_P
   } opnd_type;

   typedef enum logic [2:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADD_IF_MOVE, ACC_SUB_IF_MOVE
   } acc_op_type;

   typedef enum logic [1:0] {
      XY_NONE, XY_SET_R2, XY_R1, XY_R2
   } xy_op_type;

   typedef enum logic [1:0] {
      SAVE_NONE, SAVE_RX2, SAVE_RY2, SAVE_T
   } save_type;

   typedef enum logic [2:0] {
      EMIT_NONE, EMIT_CENTER, EMIT_M0, EMIT_M1, EMIT_M2, EMIT_M3
   } emit_type;

   typedef enum logic [2:0] {
      J_NEXT, J_IF_R2, J_IF_GT, J_END
   } jump_type;

   // one control word
   typedef struct packed {
      opnd_type            mul_a;
      opnd_type            mul_b;
      acc_op_type          acc;
      logic [1:0]          acc_shift;
      xy_op_type           xy;
      save_type            save;
      emit_type            emit;
      jump_type            jump;
      logic [PC_W-1:0]     target;
   } ucode_type;

   // sequencer to datapath
   typedef struct packed {
      logic      fire;
      logic      accept_start;
      ucode_type uword;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic active;
      logic region_two;
      logic greater;
      logic out_blocked;
   } status_type;

   function automatic ucode_type uw(
      input opnd_type        a,
      input opnd_type        b,
      input acc_op_type      acc,
      input logic [1:0]      sh,
      input xy_op_type       xy,
      input save_type        save,
      input emit_type        emit,
      input jump_type        jump,
      input logic [PC_W-1:0] target
   );
      ucode_type w;
      w.mul_a     = a;
      w.mul_b     = b;
      w.acc       = acc;
      w.acc_shift = sh;
      w.xy        = xy;
      w.save      = save;
      w.emit      = emit;
      w.jump      = jump;
      w.target    = target;
      return w;
   endfunction

   // control store: start, region 1 check and step, region switch, region 2 step
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         // start: rx2 -> d = rx2 + 4ry2 - 4rx2*ry, center and first mirrors
         PC_START: w = uw(OP_RX, OP_RX, ACC_HOLD, SH_1, XY_NONE, SAVE_NONE,
                          EMIT_CENTER, J_NEXT, PC_START);
         5'd1:  w = uw(OP_RY, OP_RY, ACC_LOAD, SH_1, XY_NONE, SAVE_RX2,
                       EMIT_M0, J_NEXT, PC_START);
         5'd2:  w = uw(OP_RX2, OP_RY, ACC_ADD, SH_4, XY_NONE, SAVE_RY2,
                       EMIT_M1, J_NEXT, PC_START);
         5'd3:  w = uw(OP_RX, OP_RX, ACC_SUB, SH_4, XY_NONE, SAVE_NONE,
                       EMIT_M2, J_NEXT, PC_START);
         5'd4:  w = uw(OP_RX, OP_RX, ACC_HOLD, SH_1, XY_NONE, SAVE_NONE,
                       EMIT_M3, J_END, PC_START);
         // advance: region test ry2*x > rx2*y
         PC_ADVANCE: w = uw(OP_RY2, OP_X, ACC_HOLD, SH_1, XY_NONE, SAVE_NONE,
                            EMIT_NONE, J_IF_R2, PC_REGION_TWO);
         5'd6:  w = uw(OP_RX2, OP_Y, ACC_HOLD, SH_1, XY_NONE, SAVE_T,
                       EMIT_NONE, J_NEXT, PC_START);
         5'd7:  w = uw(OP_RX, OP_RX, ACC_HOLD, SH_1, XY_NONE, SAVE_NONE,
                       EMIT_NONE, J_IF_GT, PC_SWITCH);
         // region 1 step: d += 8ry2*x (- 8rx2*y) + 4ry2
         5'd8:  w = uw(OP_RX, OP_RX, ACC_HOLD, SH_1, XY_R1, SAVE_NONE,
                       EMIT_NONE, J_NEXT, PC_START);
         5'd9:  w = uw(OP_RY2, OP_X, ACC_HOLD, SH_1, XY_NONE, SAVE_NONE,
                       EMIT_M0, J_NEXT, PC_START);
         5'd10: w = uw(OP_RX2, OP_Y, ACC_ADD, SH_8, XY_NONE, SAVE_NONE,
                       EMIT_M1, J_NEXT, PC_START);
         5'd11: w = uw(OP_RY, OP_RY, ACC_SUB_IF_MOVE, SH_8, XY_NONE, SAVE_NONE,
                       EMIT_M2, J_NEXT, PC_START);
         5'd12: w = uw(OP_RX, OP_RX, ACC_ADD, SH_4, XY_NONE, SAVE_NONE,
                       EMIT_M3, J_END, PC_START);
         // switch: d = (ry*xs)^2 + 4(rx*ym)^2 - 4(rx*ry)^2
         PC_SWITCH: w = uw(OP_RY, OP_XS, ACC_HOLD, SH_1, XY_SET_R2, SAVE_NONE,
                           EMIT_NONE, J_NEXT, PC_START);
         5'd14: w = uw(OP_P, OP_P, ACC_HOLD, SH_1, XY_NONE, SAVE_NONE,
                       EMIT_NONE, J_NEXT, PC_START);
         5'd15: w = uw(OP_RX, OP_YM, ACC_LOAD, SH_1, XY_NONE, SAVE_NONE,
                       EMIT_NONE, J_NEXT, PC_START);
         5'd16: w = uw(OP_P, OP_P, ACC_HOLD, SH_1, XY_NONE, SAVE_NONE,
                       EMIT_NONE, J_NEXT, PC_START);
         5'd17: w = uw(OP_RX, OP_RY, ACC_ADD, SH_4, XY_NONE, SAVE_NONE,
                       EMIT_NONE, J_NEXT, PC_START);
         5'd18: w = uw(OP_P, OP_P, ACC_HOLD, SH_1, XY_NONE, SAVE_NONE,
                       EMIT_NONE, J_NEXT, PC_START);
         5'd19: w = uw(OP_RX, OP_RX, ACC_SUB, SH_4, XY_NONE, SAVE_NONE,
                       EMIT_NONE, J_NEXT, PC_START);
         // region 2 step: d += -8rx2*y (+ 8ry2*x) + 4rx2
         PC_REGION_TWO: w = uw(OP_RX, OP_RX, ACC_HOLD, SH_1, XY_R2, SAVE_NONE,
                               EMIT_NONE, J_NEXT, PC_START);
         5'd21: w = uw(OP_RX2, OP_Y, ACC_HOLD, SH_1, XY_NONE, SAVE_NONE,
                       EMIT_M0, J_NEXT, PC_START);
         5'd22: w = uw(OP_RY2, OP_X, ACC_SUB, SH_8, XY_NONE, SAVE_NONE,
                       EMIT_M1, J_NEXT, PC_START);
         5'd23: w = uw(OP_RX, OP_RX, ACC_ADD_IF_MOVE, SH_8, XY_NONE, SAVE_NONE,
                       EMIT_M2, J_NEXT, PC_START);
         5'd24: w = uw(OP_RX, OP_RX, ACC_ADD, SH_4, XY_NONE, SAVE_NONE,
                       EMIT_M3, J_END, PC_START);
         default: w = uw(OP_RX, OP_RX, ACC_HOLD, SH_1, XY_NONE, SAVE_NONE,
                         EMIT_NONE, J_END, PC_START);
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/mer_datapath.sv =====
module mer_datapath #(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mer_pkg::ctrl_type                 ctrl,
   output mer_pkg::status_type               status,
   input  logic                              csr_write_enable,
   input  logic [mer_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mer_pkg::HALF_W-1:0]        csr_write_data,
   input  logic signed [mer_pkg::CENTER_W-1:0] req_center_x,
   input  logic signed [mer_pkg::CENTER_W-1:0] req_center_y,
   input  logic [mer_pkg::RAD_W-1:0]         req_radius_x,
   input  logic [mer_pkg::RAD_W-1:0]         req_radius_y,
   input  logic [mer_pkg::COLOR_W-1:0]       req_draw_color,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [mer_pkg::PIX_W-1:0]  rsp_pixel_x,
   output logic signed [mer_pkg::PIX_W-1:0]  rsp_pixel_y,
   output logic [mer_pkg::COLOR_W-1:0]       rsp_pixel_color,
   output logic                              rsp_last_of_run,
   output logic                              rsp_finished
);
   import mer_pkg::*;

   // configuration
   logic [HALF_W-1:0] half_x_ff, half_x_in, half_y_ff, half_y_in;

   // latched ellipse
   logic [PIX_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [RAD_W-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [SQ_W-1:0]    rx2_ff, rx2_in, ry2_ff, ry2_in;

   // walk state
   logic [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic [DEC_W-1:0]      d_ff, d_in, p_ff, p_in, t_ff, t_in;
   logic                  r2_ff, r2_in, active_ff, active_in;
   logic                  done_ff, done_in, move_ff, move_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]      px_ff, px_in, py_ff, py_in;
   logic [COLOR_W-1:0]    pc_ff, pc_in;
   logic                  last_ff, last_in, fin_ff, fin_in;

   // operands
   logic signed [COORD_BITS:0]    ym;
   logic signed [MUL_W-1:0]       mul_a, mul_b;
   logic signed [2*MUL_W-1:0]     prod;
   logic [DEC_W-1:0]              shifted;
   logic [PIX_W-1:0]              x_pix, y_pix;
   logic                          emit_now;
   logic                          vert;

   assign ym = $signed({1'b0, y_ff}) - $signed((COORD_BITS + 1)'(1));

   // shared multiplier operand select
   always_comb begin
      unique case (ctrl.uword.mul_a)
         OP_RX:   mul_a = $signed(MUL_W'(rx_ff));
         OP_RY:   mul_a = $signed(MUL_W'(ry_ff));
         OP_RX2:  mul_a = $signed(MUL_W'(rx2_ff));
         OP_RY2:  mul_a = $signed(MUL_W'(ry2_ff));
         OP_X:    mul_a = $signed(MUL_W'(x_ff));
         OP_Y:    mul_a = $signed(MUL_W'(y_ff));
         OP_XS:   mul_a = $signed(MUL_W'({x_ff, 1'b1}));
         OP_YM:   mul_a = MUL_W'(ym);
         OP_P:    mul_a = $signed(p_ff[MUL_W-1:0]);
         default: mul_a = '0;
      endcase
      unique case (ctrl.uword.mul_b)
         OP_RX:   mul_b = $signed(MUL_W'(rx_ff));
         OP_RY:   mul_b = $signed(MUL_W'(ry_ff));
         OP_RX2:  mul_b = $signed(MUL_W'(rx2_ff));
         OP_RY2:  mul_b = $signed(MUL_W'(ry2_ff));
         OP_X:    mul_b = $signed(MUL_W'(x_ff));
         OP_Y:    mul_b = $signed(MUL_W'(y_ff));
         OP_XS:   mul_b = $signed(MUL_W'({x_ff, 1'b1}));
         OP_YM:   mul_b = MUL_W'(ym);
         OP_P:    mul_b = $signed(p_ff[MUL_W-1:0]);
         default: mul_b = '0;
      endcase
   end

   assign prod    = mul_a * mul_b;
   assign shifted = p_ff << ctrl.uword.acc_shift;
   assign vert    = !d_ff[DEC_W-1] && (d_ff != '0);

   // configuration writes
   always_comb begin
      half_x_in = half_x_ff;
      half_y_in = half_y_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCREEN_HALF_X: half_x_in = csr_write_data;
            CSR_SCREEN_HALF_Y: half_y_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // ellipse latch on start
   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      color_in = color_ff;
      if (ctrl.accept_start) begin
         cx_in    = PIX_W'(half_x_ff) + PIX_W'(req_center_x);
         cy_in    = PIX_W'(half_y_ff) - PIX_W'(req_center_y);
         rx_in    = req_radius_x;
         ry_in    = req_radius_y;
         color_in = req_draw_color;
      end
   end

   // multiplier, accumulator and saved products
   always_comb begin
      p_in   = p_ff;
      d_in   = d_ff;
      t_in   = t_ff;
      rx2_in = rx2_ff;
      ry2_in = ry2_ff;
      if (ctrl.fire) begin
         p_in = prod[DEC_W-1:0];
         unique case (ctrl.uword.acc)
            ACC_HOLD:        d_in = d_ff;
            ACC_LOAD:        d_in = shifted;
            ACC_ADD:         d_in = d_ff + shifted;
            ACC_SUB:         d_in = d_ff - shifted;
            ACC_ADD_IF_MOVE: d_in = move_ff ? d_ff + shifted : d_ff;
            ACC_SUB_IF_MOVE: d_in = move_ff ? d_ff - shifted : d_ff;
            default:         d_in = d_ff;
         endcase
         unique case (ctrl.uword.save)
            SAVE_NONE: ;
            SAVE_RX2:  rx2_in = p_ff[SQ_W-1:0];
            SAVE_RY2:  ry2_in = p_ff[SQ_W-1:0];
            SAVE_T:    t_in   = p_ff;
            default: ;
         endcase
      end
   end

   // step position and region flags
   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      r2_in     = r2_ff;
      active_in = active_ff;
      done_in   = done_ff;
      move_in   = move_ff;
      if (ctrl.accept_start) begin
         x_in      = '0;
         y_in      = COORD_BITS'(req_radius_y);
         r2_in     = 1'b0;
         active_in = (req_radius_y != '0);
         done_in   = (req_radius_y == '0);
      end else if (ctrl.fire) begin
         unique case (ctrl.uword.xy)
            XY_NONE:   ;
            XY_SET_R2: r2_in = 1'b1;
            XY_R1: begin
               x_in    = x_ff + COORD_BITS'(1);
               y_in    = d_ff[DEC_W-1] ? y_ff : y_ff - COORD_BITS'(1);
               move_in = !d_ff[DEC_W-1];
            end
            XY_R2: begin
               x_in    = vert ? x_ff : x_ff + COORD_BITS'(1);
               y_in    = y_ff - COORD_BITS'(1);
               move_in = !vert;
            end
            default: ;
         endcase
         if (ctrl.uword.xy == XY_R1 || ctrl.uword.xy == XY_R2) begin
            done_in   = (y_in == '0);
            active_in = (y_in != '0);
         end
      end
   end

   // result register, loaded by emit steps
   assign emit_now = ctrl.fire && (ctrl.uword.emit != EMIT_NONE);
   assign x_pix    = PIX_W'(x_ff);
   assign y_pix    = PIX_W'(y_ff);

   always_comb begin
      px_in        = px_ff;
      py_in        = py_ff;
      pc_in        = pc_ff;
      last_in      = last_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit_now) begin
         rsp_valid_in = 1'b1;
         pc_in        = color_ff;
         fin_in       = done_ff;
         last_in      = (ctrl.uword.emit == EMIT_M3);
         unique case (ctrl.uword.emit)
            EMIT_CENTER: begin
               px_in = cx_ff;
               py_in = cy_ff;
            end
            EMIT_M0: begin
               px_in = cx_ff + x_pix;
               py_in = cy_ff - y_pix;
            end
            EMIT_M1: begin
               px_in = cx_ff + x_pix;
               py_in = cy_ff + y_pix;
            end
            EMIT_M2: begin
               px_in = cx_ff - x_pix;
               py_in = cy_ff - y_pix;
            end
            EMIT_M3: begin
               px_in = cx_ff - x_pix;
               py_in = cy_ff + y_pix;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_x_ff    <= HALF_X_RESET;
         half_y_ff    <= HALF_Y_RESET;
         x_ff         <= '0;
         y_ff         <= '0;
         d_ff         <= '0;
         r2_ff        <= 1'b0;
         active_ff    <= 1'b0;
         done_ff      <= 1'b0;
         move_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         half_x_ff    <= half_x_in;
         half_y_ff    <= half_y_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         d_ff         <= d_in;
         r2_ff        <= r2_in;
         active_ff    <= active_in;
         done_ff      <= done_in;
         move_ff      <= move_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      color_ff <= color_in;
      rx2_ff   <= rx2_in;
      ry2_ff   <= ry2_in;
      p_ff     <= p_in;
      t_ff     <= t_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      pc_ff    <= pc_in;
      last_ff  <= last_in;
      fin_ff   <= fin_in;
   end

   assign status.active      = active_ff;
   assign status.region_two  = r2_ff;
   assign status.greater     = (t_ff > p_ff);
   assign status.out_blocked = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = $signed(px_ff);
   assign rsp_pixel_y     = $signed(py_ff);
   assign rsp_pixel_color = pc_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_finished    = fin_ff;

   `include "midpoint_ellipse_rasterizer_macros.svh"

   // an emit never overwrites a result still waiting
   `MER_ASSERT_IMPL(a_no_overwrite, clock, reset, emit_now, !rsp_valid_ff || rsp_ready)
   // walk state only moves on a start or an executed step
   `MER_ASSERT_NEXT(a_walk_frozen, clock, reset, !ctrl.fire && !ctrl.accept_start, $stable(x_ff) && $stable(y_ff) && $stable(d_ff))

endmodule

// ===== hdl/mer_sequencer.sv =====
module mer_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  mer_pkg::status_type status,
   output mer_pkg::ctrl_type   ctrl
);
   import mer_pkg::*;

   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_type       uword;
   logic            accept;
   logic            fire;

   // control store read
   assign uword  = ucode_rom(pc_ff);
   assign accept = req_valid && !busy_ff;
   // an emit step waits while the result register is held
   assign fire   = busy_ff && !((uword.emit != EMIT_NONE) && status.out_blocked);

   // dispatch and step counter
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (accept) begin
         if (req_cmd == CMD_START) begin
            busy_in = 1'b1;
            pc_in   = PC_START;
         end else if (status.active) begin
            busy_in = 1'b1;
            pc_in   = PC_ADVANCE;
         end
      end else if (fire) begin
         unique case (uword.jump)
            J_NEXT:  pc_in = pc_ff + PC_W'(1);
            J_IF_R2: pc_in = status.region_two ? uword.target : pc_ff + PC_W'(1);
            J_IF_GT: pc_in = status.greater ? uword.target : pc_ff + PC_W'(1);
            J_END: begin
               busy_in = 1'b0;
               pc_in   = PC_START;
            end
            default: begin
               busy_in = 1'b0;
               pc_in   = PC_START;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_START;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign req_ready         = !busy_ff;
   assign ctrl.fire         = fire;
   assign ctrl.accept_start = accept && (req_cmd == CMD_START);
   assign ctrl.uword        = uword;

   `include "midpoint_ellipse_rasterizer_macros.svh"

   // a held step keeps its place
   `MER_ASSERT_NEXT(a_stall_holds_pc, clock, reset, busy_ff && !fire, busy_ff && $stable(pc_ff))
   // the last step of a program frees the input
   `MER_ASSERT_NEXT(a_end_goes_idle, clock, reset, fire && uword.jump == J_END, !busy_ff)

endmodule

// ===== hdl/midpoint_ellipse_rasterizer.sv =====
// Axis-aligned ellipse rasterizer, midpoint decision method, one step per item.
// Input channel req_*: req_cmd selects start (latches center, radii, color) or
// advance (one step of region 1 or region 2). Result channel rsp_*: pixels in
// screen coordinates, rsp_last_of_run on the last pixel of an item, rsp_finished
// on every pixel of the item that completes the ellipse. csr_* sets the screen
// origin offsets and must be written by the user only while the block is idle;
// the block itself does not enforce this. A control store sequences one shared
// 32x32 multiplier and a 48-bit decision accumulator; req_ready is high only
// between items. A start emits 5 pixels; a region 1 advance, a region 2 advance
// and the advance that changes region emit 4 pixels each; an advance after the
// ellipse is done emits no pixels. The pixels of an item follow one per cycle
// while the receiver is ready.
// A stalled receiver holds the result register and freezes the sequencer at its
// next pixel step; no pixel is dropped or repeated.
// Reset clears the sequencer and result valid, leaves the block idle with no
// ellipse active and restores the screen offsets to 320 and 240.
module midpoint_ellipse_rasterizer #(
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [mer_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mer_pkg::HALF_W-1:0]          csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic signed [mer_pkg::CENTER_W-1:0] req_center_x,
   input  logic signed [mer_pkg::CENTER_W-1:0] req_center_y,
   input  logic [mer_pkg::RAD_W-1:0]           req_radius_x,
   input  logic [mer_pkg::RAD_W-1:0]           req_radius_y,
   input  logic [mer_pkg::COLOR_W-1:0]         req_draw_color,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mer_pkg::PIX_W-1:0]    rsp_pixel_x,
   output logic signed [mer_pkg::PIX_W-1:0]    rsp_pixel_y,
   output logic [mer_pkg::COLOR_W-1:0]         rsp_pixel_color,
   output logic                                rsp_last_of_run,
   output logic                                rsp_finished
);
   import mer_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   // program counter and dispatch
   mer_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .status    (status),
      .ctrl      (ctrl)
   );

   // arithmetic, walk state and result register
   mer_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius_x     (req_radius_x),
      .req_radius_y     (req_radius_y),
      .req_draw_color   (req_draw_color),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_finished     (rsp_finished)
   );

endmodule
